FILE: rtl/core/bsc_pkg.sv
// Shared types, operation codes and constants of the barometric compensation block.
package bsc_pkg;

	typedef struct packed {
		logic        command;
		logic [23:0] raw_sample;
	} in_word_t;

	typedef struct packed {
		logic               sample_kind;
		logic signed [27:0] temperature_tenths;
		logic signed [31:0] pressure_pa;
		logic               div_fault;
	} out_word_t;

	typedef struct packed {
		logic [31:0] ac1_ac2;
		logic [31:0] ac3_ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [1:0]  oss;
	} cal_t;

	typedef struct packed {
		logic       load;
		logic       run;
		logic [4:0] op;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_zero;
		logic div_done;
	} dp_stat_t;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	// Datapath operations, issued in ascending order
	localparam logic [4:0] OP_T_MUL  = 5'd0;
	localparam logic [4:0] OP_T_X1   = 5'd1;
	localparam logic [4:0] OP_T_DIV  = 5'd2;
	localparam logic [4:0] OP_T_FIN  = 5'd3;
	localparam logic [4:0] OP_P_B6   = 5'd4;
	localparam logic [4:0] OP_P_SQ   = 5'd5;
	localparam logic [4:0] OP_P_X2   = 5'd6;
	localparam logic [4:0] OP_P_X1   = 5'd7;
	localparam logic [4:0] OP_P_B3   = 5'd8;
	localparam logic [4:0] OP_P_X3A  = 5'd9;
	localparam logic [4:0] OP_P_X3B  = 5'd10;
	localparam logic [4:0] OP_P_B4   = 5'd11;
	localparam logic [4:0] OP_P_B4W  = 5'd12;
	localparam logic [4:0] OP_P_DIV  = 5'd13;
	localparam logic [4:0] OP_P_P    = 5'd14;
	localparam logic [4:0] OP_P_SQP  = 5'd15;
	localparam logic [4:0] OP_P_M1   = 5'd16;
	localparam logic [4:0] OP_P_M2   = 5'd17;
	localparam logic [4:0] OP_P_FIN  = 5'd18;

	localparam logic [31:0] B6_OFFSET  = 32'd4000;
	localparam logic [32:0] K_3038     = 33'd3038;
	localparam logic [32:0] K_M7357    = -33'sd7357;
	localparam logic [33:0] K_3791     = 34'd3791;
	localparam logic [15:0] K_50000    = 16'd50000;
	localparam logic [31:0] K_32768    = 32'd32768;

endpackage

FILE: rtl/core/bsc_div.sv
// Restoring unsigned 32-by-32 divider, one quotient bit per cycle.
module bsc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [32:0] trial;

	assign rem_sh = {rem_q, quo_q[31]};
	assign trial  = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: rtl/core/bsc_dp.sv
// Compensation datapath: shared multiplier, divider, kept terms and result register.
module bsc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bsc_pkg::cal_t         cal,
	input  bsc_pkg::in_word_t     in_data,
	input  bsc_pkg::ctrl_cmd_t    cmd,
	output bsc_pkg::dp_stat_t     stat,
	output bsc_pkg::out_word_t    out_data
);
	logic [23:0]        raw_q;
	logic               kind_q;
	logic               fault_q;
	logic signed [31:0] b5_q;
	logic signed [27:0] temp_q;
	logic signed [31:0] pres_q;
	logic [31:0] x1_q, x2_q, x3_q, b6_q, sq_q, b3_q, b4_q, b7_q, p_q, up_q;
	logic        sign_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_s1;
	bsc_pkg::out_word_t out_q;

	logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [16:0] tdiff;
	logic [31:0] tden, num32, num_mag, den_mag, div_a, div_b, quo;
	logic [31:0] x2t, b5n, x3p, sub_up;
	logic [32:0] tsum;
	logic [37:0] b3sum, b3sh;
	logic [33:0] x3sum, psum;
	logic        div_zero, div_start, div_done;

	assign ac1 = cal.ac1_ac2[31:16];
	assign ac2 = cal.ac1_ac2[15:0];
	assign ac3 = cal.ac3_ac4[31:16];
	assign ac4 = cal.ac3_ac4[15:0];
	assign ac5 = cal.ac5_ac6[31:16];
	assign ac6 = cal.ac5_ac6[15:0];
	assign b1  = cal.b1_b2[31:16];
	assign b2  = cal.b1_b2[15:0];
	assign mc  = cal.mc_md[31:16];
	assign md  = cal.mc_md[15:0];

	// temperature terms
	assign tdiff   = {1'b0, raw_q[15:0]} - {1'b0, ac6};
	assign tden    = x1_q + {{16{md[15]}}, md};
	assign num32   = {{5{mc[15]}}, mc, 11'd0};
	assign num_mag = num32[31] ? (32'd0 - num32) : num32;
	assign den_mag = tden[31] ? (32'd0 - tden) : tden;
	assign x2t     = sign_q ? (32'd0 - quo) : quo;
	assign b5n     = x1_q + x2t;
	assign tsum    = {b5n[31], b5n} + 33'd8;

	// pressure terms
	assign x3p    = x1_q + x2_q;
	assign b3sum  = {{20{ac1[15]}}, ac1, 2'b00} + {{6{x3p[31]}}, x3p};
	assign b3sh   = (b3sum << cal.oss) + 38'd2;
	assign x3sum  = {{2{x1_q[31]}}, x1_q} + {{2{prod_s1[47]}}, prod_s1[47:16]} + 34'd2;
	assign sub_up = up_q - b3_q;
	assign psum   = {{2{prod_s1[47]}}, prod_s1[47:16]} + {{2{x2_q[31]}}, x2_q}
		+ bsc_pkg::K_3791;

	always_comb begin
		div_zero  = 1'b0;
		div_start = 1'b0;
		div_a     = num_mag;
		div_b     = den_mag;
		ma        = '0;
		mb        = '0;
		if (cmd.op == bsc_pkg::OP_T_DIV) begin
			div_zero = (tden == 32'd0);
		end else if (cmd.op == bsc_pkg::OP_P_DIV) begin
			div_zero = (b4_q == 32'd0);
			div_a    = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
			div_b    = b4_q;
		end
		div_start = cmd.run && !div_zero &&
			(cmd.op == bsc_pkg::OP_T_DIV || cmd.op == bsc_pkg::OP_P_DIV);
		case (cmd.op)
			bsc_pkg::OP_T_MUL: begin
				ma = {{16{tdiff[16]}}, tdiff};
				mb = {17'd0, ac5};
			end
			bsc_pkg::OP_P_SQ: begin
				ma = {b6_q[31], b6_q};
				mb = {b6_q[31], b6_q};
			end
			bsc_pkg::OP_P_X2: begin
				ma = {{17{ac2[15]}}, ac2};
				mb = {b6_q[31], b6_q};
			end
			bsc_pkg::OP_P_X1: begin
				ma = {{17{b2[15]}}, b2};
				mb = {sq_q[31], sq_q};
			end
			bsc_pkg::OP_P_B3: begin
				ma = {{17{ac3[15]}}, ac3};
				mb = {b6_q[31], b6_q};
			end
			bsc_pkg::OP_P_X3A: begin
				ma = {{17{b1[15]}}, b1};
				mb = {sq_q[31], sq_q};
			end
			bsc_pkg::OP_P_X3B: begin
				ma = {1'b0, sub_up};
				mb = {17'd0, bsc_pkg::K_50000 >> cal.oss};
			end
			bsc_pkg::OP_P_B4: begin
				ma = {17'd0, ac4};
				mb = {1'b0, x3_q + bsc_pkg::K_32768};
			end
			bsc_pkg::OP_P_SQP: begin
				ma = {{9{p_q[31]}}, p_q[31:8]};
				mb = {{9{p_q[31]}}, p_q[31:8]};
			end
			bsc_pkg::OP_P_M1: begin
				ma = {p_q[31], p_q};
				mb = bsc_pkg::K_M7357;
			end
			bsc_pkg::OP_P_M2: begin
				ma = {x1_q[31], x1_q};
				mb = bsc_pkg::K_3038;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
	end

	// kept state and fault flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q    <= '0;
			temp_q  <= '0;
			pres_q  <= '0;
			fault_q <= 1'b0;
		end else if (cmd.load) begin
			fault_q <= 1'b0;
		end else if (cmd.run) begin
			if (div_zero)
				fault_q <= 1'b1;
			if (cmd.op == bsc_pkg::OP_T_FIN) begin
				b5_q   <= b5n;
				temp_q <= tsum[31:4];
			end
			if (cmd.op == bsc_pkg::OP_P_FIN)
				pres_q <= p_q + {{2{psum[33]}}, psum[33:4]};
		end
	end

	// working terms
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q  <= in_data.raw_sample;
			kind_q <= in_data.command;
		end else if (cmd.run) begin
			case (cmd.op)
				bsc_pkg::OP_T_X1:  x1_q <= prod_s1[46:15];
				bsc_pkg::OP_T_DIV: sign_q <= num32[31] ^ tden[31];
				bsc_pkg::OP_P_B6: begin
					b6_q <= b5_q - bsc_pkg::B6_OFFSET;
					up_q <= {8'd0, raw_q} >> (4'd8 - {2'b00, cal.oss});
				end
				bsc_pkg::OP_P_X2:  sq_q <= prod_s1[43:12];
				bsc_pkg::OP_P_X1:  x2_q <= prod_s1[42:11];
				bsc_pkg::OP_P_B3:  x1_q <= prod_s1[42:11];
				bsc_pkg::OP_P_X3A: begin
					b3_q <= b3sh[33:2];
					x1_q <= prod_s1[44:13];
				end
				bsc_pkg::OP_P_X3B: x3_q <= x3sum[33:2];
				bsc_pkg::OP_P_B4:  b7_q <= prod_s1[31:0];
				bsc_pkg::OP_P_B4W: b4_q <= prod_s1[46:15];
				bsc_pkg::OP_P_P:   p_q <= b7_q[31] ? {quo[30:0], 1'b0} : quo;
				bsc_pkg::OP_P_M1:  x1_q <= prod_s1[31:0];
				bsc_pkg::OP_P_M2:  x2_q <= prod_s1[47:16];
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.sample_kind        <= kind_q;
			out_q.temperature_tenths <= temp_q;
			out_q.pressure_pa        <= pres_q;
			out_q.div_fault          <= fault_q;
		end
	end

	assign stat.div_zero = div_zero;
	assign stat.div_done = div_done;
	assign out_data      = out_q;
endmodule

FILE: rtl/core/bsc_ctrl.sv
// Sequencer: steps the datapath through the temperature or pressure operation list.
module bsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_command,
	input  logic               out_stall,
	input  bsc_pkg::dp_stat_t  stat,
	output bsc_pkg::ctrl_cmd_t cmd,
	output logic               in_stall,
	output logic               out_valid
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DIVW = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [4:0] op_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.run      = (state_q == ST_RUN);
		cmd.op       = op_q;
		cmd.out_load = (state_q == ST_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= bsc_pkg::OP_T_MUL;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= in_command ? bsc_pkg::OP_P_B6 : bsc_pkg::OP_T_MUL;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (op_q == bsc_pkg::OP_T_DIV || op_q == bsc_pkg::OP_P_DIV) begin
						state_q <= stat.div_zero ? ST_FIN : ST_DIVW;
					end else if (op_q == bsc_pkg::OP_T_FIN || op_q == bsc_pkg::OP_P_FIN) begin
						state_q <= ST_FIN;
					end else begin
						op_q <= op_q + 5'd1;
					end
				end
				ST_DIVW: begin
					if (stat.div_done) begin
						op_q    <= op_q + 5'd1;
						state_q <= ST_RUN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
endmodule

FILE: rtl/core/baro_sensor_compensation.sv
// Sequence: a temperature or pressure word runs through the serial divider and the steps of
//   the shared 33x33 multiplier to a valid result; a zero divisor skips the divider.
// Throughput: one word at a time, taken the cycle after the previous result enters the
//   output register even if that result is still stalled.
// Reset (arst_n low, async): calibration, kept B5, temperature, pressure clear; idle, no word.
module baro_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	// sample channel
	input  logic               in_valid,
	output logic               in_stall,
	input  bsc_pkg::in_word_t  in_data,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output bsc_pkg::out_word_t out_data,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	bsc_pkg::cal_t      cal_q;
	bsc_pkg::ctrl_cmd_t cmd;
	bsc_pkg::dp_stat_t  stat;
	logic [2:0]         reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	// Take a register write at the access phase; writes beyond the list drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				bsc_pkg::REG_AC1_AC2: cal_q.ac1_ac2 <= pwdata;
				bsc_pkg::REG_AC3_AC4: cal_q.ac3_ac4 <= pwdata;
				bsc_pkg::REG_AC5_AC6: cal_q.ac5_ac6 <= pwdata;
				bsc_pkg::REG_B1_B2:   cal_q.b1_b2   <= pwdata;
				bsc_pkg::REG_MC_MD:   cal_q.mc_md   <= pwdata;
				bsc_pkg::REG_OSS:     cal_q.oss     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register; unused addresses read zero.
	always_comb begin
		case (reg_idx)
			bsc_pkg::REG_AC1_AC2: prdata = cal_q.ac1_ac2;
			bsc_pkg::REG_AC3_AC4: prdata = cal_q.ac3_ac4;
			bsc_pkg::REG_AC5_AC6: prdata = cal_q.ac5_ac6;
			bsc_pkg::REG_B1_B2:   prdata = cal_q.b1_b2;
			bsc_pkg::REG_MC_MD:   prdata = cal_q.mc_md;
			bsc_pkg::REG_OSS:     prdata = {30'd0, cal_q.oss};
			default:              prdata = 32'd0;
		endcase
	end

	// Sequencer: accept a word, walk the operation list, park the result.
	bsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.out_stall  (out_stall),
		.stat       (stat),
		.cmd        (cmd),
		.in_stall   (in_stall),
		.out_valid  (out_valid)
	);

	// Datapath: multiplier, divider, kept B5/temperature/pressure, output register.
	bsc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal_q),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);
endmodule

FILE: rtl/core/bsc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
module bsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input bsc_pkg::out_word_t out_data
);
	// an accepted word keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a word");

	// a new result only appears at the end of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
